// ----- rtl/mlb_pkg.sv -----
// shared types and constants for the mutex lock bank
package mlb_pkg;

    localparam int NUM_LOCKS = 16;
    localparam int ID_WIDTH  = 8;
    localparam int DEPTH_MAX = 255;
    localparam int ADDR_W    = $clog2(NUM_LOCKS);

    // command codes
    localparam logic [2:0] CMD_INIT    = 3'd0;
    localparam logic [2:0] CMD_LOCK    = 3'd1;
    localparam logic [2:0] CMD_TRYLOCK = 3'd2;
    localparam logic [2:0] CMD_UNLOCK  = 3'd3;
    localparam logic [2:0] CMD_DESTROY = 3'd4;

    // mutex kinds
    localparam logic [1:0] KIND_DEFAULT = 2'd0;
    localparam logic [1:0] KIND_ERRCHK  = 2'd1;
    localparam logic [1:0] KIND_RECUR   = 2'd2;
    localparam logic [1:0] KIND_INVALID = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BUSY     = 3'd1;
    localparam logic [2:0] ST_DEADLOCK = 3'd2;
    localparam logic [2:0] ST_NOTOWNER = 3'd3;
    localparam logic [2:0] ST_INVALID  = 3'd4;
    localparam logic [2:0] ST_OVERFLOW = 3'd5;

    // one stored lock
    typedef struct packed {
        logic                held;
        logic [ID_WIDTH-1:0] owner;
        logic [7:0]          depth;
        logic [1:0]          kind;
    } mlb_entry_t;

    typedef enum logic {
        S_IDLE,
        S_READ
    } mlb_state_t;

endpackage

// ----- rtl/mlb_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
module mlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/mutex_lock_bank_top.sv -----
// top level of the mutex lock bank: request decode, state ram and result register
//
// a bank of sixteen hardware mutexes. each item on the input stream names a
// command (init, lock, trylock, unlock, destroy check), a lock index, the
// requesting thread and, for init, the mutex kind (default, errorcheck or
// recursive). the block answers every item with exactly one result item: a
// status code and the lock's held flag, holder and nesting depth after the
// request. a lock that would block answers busy at once. all lock state sits
// in one small ram with a registered read; each item is a read of its entry
// followed by a modify-write: accept and read in the idle state, then update
// and result in the read state, which waits while the output register is
// full; no new item is accepted before that result is loaded. the result
// sits in an output register, so the next item can be read while a result
// still waits to be taken. per-entry valid bits make every lock read as free,
// owner 0, depth 0, default kind after reset, so no clearing pass is needed.
module mutex_lock_bank_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // command[2:0], lock_index[6:3], thread_id[14:7],
                                   // mutex_kind[16:15], zero pad[23:17]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // status[2:0], held[3], holder[11:4], nesting[19:12],
                                   // zero pad[23:20]
);

    localparam int EW = $bits(mlb_pkg::mlb_entry_t);

    // input fields
    logic [2:0]                  in_command;
    logic [3:0]                  in_lock_index;
    logic [7:0]                  in_thread_id;
    logic [1:0]                  in_mutex_kind;

    assign in_command    = s_tdata[2:0];
    assign in_lock_index = s_tdata[6:3];
    assign in_thread_id  = s_tdata[14:7];
    assign in_mutex_kind = s_tdata[16:15];

    mlb_pkg::mlb_state_t state_reg, state_next;

    // request held while its entry is read
    logic [2:0]                     cmd_reg;
    logic [mlb_pkg::ID_WIDTH-1:0]   tid_reg;
    logic [1:0]                     kind_reg;
    logic [mlb_pkg::ADDR_W-1:0]     addr_reg;
    logic                           idx_ok_reg;
    logic                           rd_valid_reg;

    // entry written since reset
    logic [mlb_pkg::NUM_LOCKS-1:0]  valid_reg;

    // result register
    logic                           m_tvalid_reg;
    logic [2:0]                     status_reg, status_next;
    logic                           held_reg;
    logic [7:0]                     holder_reg, holder_next;
    logic [7:0]                     nesting_reg;

    logic                           in_accept;
    logic                           out_load;
    logic                           ram_we;
    logic [EW-1:0]                  ram_rdata;
    mlb_pkg::mlb_entry_t            cur_entry;
    mlb_pkg::mlb_entry_t            new_entry;
    logic                           idx_ok;
    logic                           mine;
    logic                           upd_we;

    assign idx_ok    = 32'(in_lock_index) < mlb_pkg::NUM_LOCKS;
    assign in_accept = s_tvalid && s_tready;

    // lock state memory
    mlb_ram #(
        .WIDTH (EW),
        .DEPTH (mlb_pkg::NUM_LOCKS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (new_entry),
        .re    (in_accept),
        .raddr (in_lock_index[mlb_pkg::ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // an entry never written reads as the reset value
    assign cur_entry = rd_valid_reg ? mlb_pkg::mlb_entry_t'(ram_rdata) : '0;
    assign mine      = cur_entry.held && (cur_entry.owner == tid_reg);

    // sequencer: one request in flight, result loaded when the output is free
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            mlb_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = mlb_pkg::S_READ;
                end
            end
            mlb_pkg::S_READ:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = mlb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mlb_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mlb_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // read-modify of the addressed lock
    always_comb
    begin
        new_entry   = cur_entry;
        status_next = mlb_pkg::ST_OK;
        upd_we      = 1'b0;
        unique case (cmd_reg) inside
            mlb_pkg::CMD_INIT:
            begin
                if (kind_reg == mlb_pkg::KIND_INVALID)
                begin
                    status_next = mlb_pkg::ST_INVALID;
                end
                else
                begin
                    new_entry      = '0;
                    new_entry.kind = kind_reg;
                    upd_we         = 1'b1;
                end
            end
            mlb_pkg::CMD_LOCK, mlb_pkg::CMD_TRYLOCK:
            begin
                if (mine && cur_entry.kind == mlb_pkg::KIND_RECUR)
                begin
                    if (32'(cur_entry.depth) >= mlb_pkg::DEPTH_MAX)
                    begin
                        status_next = mlb_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        new_entry.depth = cur_entry.depth + 8'd1;
                        upd_we          = 1'b1;
                    end
                end
                else if (mine && cur_entry.kind == mlb_pkg::KIND_ERRCHK
                         && cmd_reg == mlb_pkg::CMD_LOCK)
                begin
                    status_next = mlb_pkg::ST_DEADLOCK;
                end
                else if (cur_entry.held)
                begin
                    status_next = mlb_pkg::ST_BUSY;
                end
                else
                begin
                    new_entry.held  = 1'b1;
                    new_entry.owner = tid_reg;
                    new_entry.depth = 8'd1;
                    upd_we          = 1'b1;
                end
            end
            mlb_pkg::CMD_UNLOCK:
            begin
                if (cur_entry.kind == mlb_pkg::KIND_DEFAULT)
                begin
                    new_entry.held  = 1'b0;
                    new_entry.owner = '0;
                    new_entry.depth = '0;
                    upd_we          = 1'b1;
                end
                else if (!mine)
                begin
                    status_next = mlb_pkg::ST_NOTOWNER;
                end
                else if (cur_entry.kind == mlb_pkg::KIND_RECUR && cur_entry.depth > 8'd1)
                begin
                    new_entry.depth = cur_entry.depth - 8'd1;
                    upd_we          = 1'b1;
                end
                else
                begin
                    new_entry.held  = 1'b0;
                    new_entry.owner = '0;
                    new_entry.depth = '0;
                    upd_we          = 1'b1;
                end
            end
            mlb_pkg::CMD_DESTROY:
            begin
                status_next = cur_entry.held ? mlb_pkg::ST_BUSY : mlb_pkg::ST_OK;
            end
            default:
            begin
                // unknown command: report the lock untouched
                status_next = mlb_pkg::ST_OK;
            end
        endcase
        if (!idx_ok_reg)
        begin
            status_next = mlb_pkg::ST_INVALID;
            new_entry   = '0;
            upd_we      = 1'b0;
        end
        holder_next = new_entry.held ? 8'(new_entry.owner) : 8'd0;
    end

    assign ram_we = out_load && upd_we;

    // request capture
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg      <= in_command;
            tid_reg      <= in_thread_id[mlb_pkg::ID_WIDTH-1:0];
            kind_reg     <= in_mutex_kind;
            addr_reg     <= in_lock_index[mlb_pkg::ADDR_W-1:0];
            idx_ok_reg   <= idx_ok;
            rd_valid_reg <= valid_reg[in_lock_index[mlb_pkg::ADDR_W-1:0]];
        end
    end

    // valid bits stand in for clearing the ram after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ram_we)
        begin
            valid_reg[addr_reg] <= 1'b1;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg  <= status_next;
            held_reg    <= new_entry.held;
            holder_reg  <= holder_next;
            nesting_reg <= new_entry.depth;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, nesting_reg, holder_reg, held_reg, status_reg};

    // one request at a time: no new item straight after an accepted one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_tready)
        else $error("item accepted while another is in flight");

    // every state update is paired with a result
    a_write_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> m_tvalid)
        else $error("state written without a result");

    // a held lock always has a nonzero depth
    a_held_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && held_reg) |-> (nesting_reg != 8'd0))
        else $error("held lock reported with zero depth");

    // a free lock reports no holder and no depth
    a_free_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !held_reg) |-> (holder_reg == 8'd0 && nesting_reg == 8'd0))
        else $error("free lock reported with holder or depth");

endmodule
